// ===== design/s256_pkg.sv =====
// ----------------------------------------------------------------------------
// s256_pkg
// shared types, round constants and bit functions of the sha-256 hasher
// ----------------------------------------------------------------------------
package s256_pkg;

  typedef logic [31:0]      word_t;
  typedef logic [7:0][31:0] hash_t;

  typedef struct packed {
    logic start;   // load block and run the rounds
    logic reinit;  // return the hash words to the initial values
  } s256_ctl_t;

  typedef struct packed {
    logic busy;
  } s256_sts_t;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned BlockBits = 512;

  localparam word_t RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // element 0 is digest word 0
  localparam hash_t StartHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sig0(input word_t x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t sml_sig0(input word_t x);
    sml_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sml_sig1(input word_t x);
    sml_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    choose = (e & f) ^ (~e & g);
  endfunction

  function automatic word_t major(input word_t a, input word_t b, input word_t c);
    major = (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

// ===== design/s256_engine.sv =====
// ----------------------------------------------------------------------------
// s256_engine
// compression unit: one round per cycle over a 16-word schedule window
// ----------------------------------------------------------------------------
module s256_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  s256_pkg::s256_ctl_t          ctl_i,
  input  logic [s256_pkg::BlockBits-1:0] blk_i,   // first message byte in the top bits
  output s256_pkg::s256_sts_t          sts_o,
  output s256_pkg::hash_t              hash_o
);

  import s256_pkg::*;

  typedef enum logic [2:0] {
    E_IDLE  = 3'b001,
    E_ROUND = 3'b010,
    E_ADD   = 3'b100
  } eng_state_t;

  eng_state_t  state_r, state_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  hash_t       hash_r, hash_nxt;
  word_t       v_r [8];
  word_t       v_nxt [8];
  word_t       w_r [16];
  word_t       w_nxt [16];

  word_t t1, t2, w_new;

  always_comb begin
    t1    = v_r[7] + big_sig1(v_r[4]) + choose(v_r[4], v_r[5], v_r[6])
          + RoundK[rnd_r] + w_r[0];
    t2    = big_sig0(v_r[0]) + major(v_r[0], v_r[1], v_r[2]);
    w_new = sml_sig1(w_r[14]) + w_r[9] + sml_sig0(w_r[1]) + w_r[0];
  end

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    hash_nxt  = hash_r;
    v_nxt     = v_r;
    w_nxt     = w_r;
    unique case (state_r)
      E_IDLE: begin
        if (ctl_i.reinit) begin
          hash_nxt = StartHash;
        end
        if (ctl_i.start) begin
          for (int i = 0; i < 8; i++) begin
            v_nxt[i] = hash_r[i];
          end
          for (int i = 0; i < 16; i++) begin
            w_nxt[i] = blk_i[BlockBits-1-32*i -: 32];
          end
          rnd_nxt   = '0;
          state_nxt = E_ROUND;
        end
      end
      E_ROUND: begin
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        // schedule window slides by one word per round
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[15] = w_new;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == 6'(NumRounds - 1)) begin
          state_nxt = E_ADD;
        end
      end
      E_ADD: begin
        for (int i = 0; i < 8; i++) begin
          hash_nxt[i] = hash_r[i] + v_r[i];
        end
        state_nxt = E_IDLE;
      end
      default: begin
        state_nxt = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      rnd_r   <= '0;
      hash_r  <= StartHash;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      hash_r  <= hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    w_r <= w_nxt;
  end

  assign sts_o.busy = (state_r != E_IDLE);
  assign hash_o     = hash_r;

endmodule

// ===== design/sha256_stream_hasher_top.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// byte-stream sha-256: block gathering, padding and digest output
// ----------------------------------------------------------------------------
// one byte transfer per cycle while gathering; every 64th byte hands the block to
// the shared round unit (64 rounds, hash add, hand-back), during which no bytes are
// taken. end of message adds padding bytes, one or two compressions, then eight
// digest transfers, one per cycle while out_tready is high.
// reset restores the initial hash and clears counters; the byte buffer is not cleared.
module sha256_stream_hasher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] byte_valid
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast   // last_word
);

  import s256_pkg::*;

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_WAIT = 4'b0010,
    T_PAD  = 4'b0100,
    T_OUT  = 4'b1000
  } top_state_t;

  top_state_t           state_r, state_nxt;
  logic [BlockBits-1:0] buf_r, buf_nxt;
  logic [5:0]           fill_r, fill_nxt;
  logic [63:0]          bits_r, bits_nxt;
  logic                 start_r, start_nxt;
  logic                 fin_r, fin_nxt;
  logic                 sent80_r, sent80_nxt;
  logic                 len_ph_r, len_ph_nxt;
  logic [2:0]           oidx_r, oidx_nxt;

  logic       push_en;
  logic [7:0] push_byte;
  logic       in_xfer, out_xfer;
  s256_ctl_t  eng_ctl;
  s256_sts_t  eng_sts;
  hash_t      eng_hash;

  assign in_tready  = (state_r == T_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = (state_r == T_OUT);
  assign out_xfer   = out_tvalid && out_tready;
  assign out_tdata  = eng_hash[oidx_r];
  assign out_tuser  = oidx_r;
  assign out_tlast  = (oidx_r == 3'd7);

  always_comb begin
    state_nxt      = state_r;
    bits_nxt       = bits_r;
    fin_nxt        = fin_r;
    sent80_nxt     = sent80_r;
    len_ph_nxt     = len_ph_r;
    oidx_nxt       = oidx_r;
    push_en        = 1'b0;
    push_byte      = in_tdata;
    eng_ctl.reinit = 1'b0;
    // start is registered, so it rises in the cycle after the last byte and the engine sees the full buffer
    eng_ctl.start  = start_r;
    unique case (state_r)
      T_IDLE: begin
        if (in_xfer) begin
          push_en = in_tuser;
          fin_nxt = in_tlast;
          if (in_tuser) begin
            bits_nxt = bits_r + 64'd8;
          end
          priority if (in_tuser && fill_r == 6'd63) begin
            state_nxt = T_WAIT;
          end else if (in_tlast) begin
            state_nxt = T_PAD;
          end
        end
      end
      T_PAD: begin
        push_en = 1'b1;
        priority if (!sent80_r) begin
          push_byte  = PadMark;
          sent80_nxt = 1'b1;
        end else if (len_ph_r || fill_r == LenPos) begin
          // length goes out big-endian, shifted off the top of the counter
          push_byte  = bits_r[63:56];
          bits_nxt   = {bits_r[55:0], 8'h00};
          len_ph_nxt = 1'b1;
        end else begin
          push_byte = 8'h00;
        end
        if (fill_r == 6'd63) begin
          state_nxt = T_WAIT;
        end
      end
      T_WAIT: begin
        if (!start_r && !eng_sts.busy) begin
          priority if (!fin_r) begin
            state_nxt = T_IDLE;
          end else if (len_ph_r) begin
            state_nxt = T_OUT;
          end else begin
            state_nxt = T_PAD;
          end
        end
      end
      T_OUT: begin
        if (out_xfer) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            eng_ctl.reinit = 1'b1;
            bits_nxt       = '0;
            fin_nxt        = 1'b0;
            sent80_nxt     = 1'b0;
            len_ph_nxt     = 1'b0;
            state_nxt      = T_IDLE;
          end
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_comb begin
    buf_nxt   = buf_r;
    fill_nxt  = fill_r;
    start_nxt = 1'b0;
    if (push_en) begin
      buf_nxt   = {buf_r[BlockBits-9:0], push_byte};
      fill_nxt  = fill_r + 6'd1;
      start_nxt = (fill_r == 6'd63);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= T_IDLE;
      fill_r   <= '0;
      bits_r   <= '0;
      start_r  <= 1'b0;
      fin_r    <= 1'b0;
      sent80_r <= 1'b0;
      len_ph_r <= 1'b0;
      oidx_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      bits_r   <= bits_nxt;
      start_r  <= start_nxt;
      fin_r    <= fin_nxt;
      sent80_r <= sent80_nxt;
      len_ph_r <= len_ph_nxt;
      oidx_r   <= oidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  s256_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (eng_ctl),
    .blk_i  (buf_r),
    .sts_o  (eng_sts),
    .hash_o (eng_hash)
  );

endmodule
